// ===== design/pin_change_report_engine_defines.svh =====
// Assertion macros shared by the pin change report engine.
`ifndef PIN_CHANGE_REPORT_ENGINE_DEFINES_SVH
`define PIN_CHANGE_REPORT_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PCRE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pin change report engine: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PCRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pin change report engine: next-cycle check failed");

`endif

// ===== design/pcre_pkg.sv =====
// Package of constants and codes for the pin change report engine.
`timescale 1ns / 1ps
package pcre_pkg;

    localparam int DIGITAL_PINS    = 64;
    localparam int ANALOG_CHANNELS = 16;
    localparam int ADC_BITS        = 10;

    localparam int DIG_AW = (DIGITAL_PINS > 1) ? $clog2(DIGITAL_PINS) : 1;
    localparam int ANA_AW = (ANALOG_CHANNELS > 1) ? $clog2(ANALOG_CHANNELS) : 1;

    localparam int CMD_W    = 4;
    localparam int PIN_W    = 6;
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 10;
    localparam int TIME_W   = 32;
    localparam int IVL_W    = 8;
    localparam int MODE_W   = 2;

    localparam logic [IVL_W-1:0] DEFAULT_INTERVAL = 8'd19;
    localparam logic [VALUE_W-1:0] ADC_MASK =
        VALUE_W'((33'd1 << ADC_BITS) - 33'd1);

    // Word layouts of the two tables.
    localparam int DIG_WORD_W = MODE_W + 1;
    localparam int ANA_WORD_W = 2 * VALUE_W;

    localparam logic [CMD_W-1:0] CMD_INPUT         = 4'd0;
    localparam logic [CMD_W-1:0] CMD_PULLUP        = 4'd1;
    localparam logic [CMD_W-1:0] CMD_OUTPUT        = 4'd2;
    localparam logic [CMD_W-1:0] CMD_ANALOG        = 4'd3;
    localparam logic [CMD_W-1:0] CMD_REPORTING     = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DIG_SAMPLE    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_SCAN_BEGIN    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_ANA_SAMPLE    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_RESET_TIMING  = 4'd8;

    localparam logic [ACTION_W-1:0] ACT_DISABLE_ALL = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ANALOG_ON   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ANALOG_OFF  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DIGITAL_ON  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DIGITAL_OFF = 3'd4;

    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INPUT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PULLUP = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OUTPUT = 2'd3;

    localparam logic REPORT_DIGITAL = 1'b0;
    localparam logic REPORT_ANALOG  = 1'b1;

endpackage

// ===== design/pin_change_report_engine.sv =====
// Top level of the pin change report engine: command decode, table update and reporting.
`timescale 1ns / 1ps
`include "pin_change_report_engine_defines.svh"
//
// Channel     | Handshake                      | Payload
// ------------+--------------------------------+----------------------------------------------
// command     | start in, busy out             | i_cmd, i_pin, i_report_on, i_threshold,
//             |                                | i_reporting_action, i_sample, i_now_ms
// config      | i_cfg_valid in, o_cfg_ready out| i_cfg_data (sampling interval in ms)
// report      | o_report_valid strobe out      | o_report_kind, o_report_pin, o_report_value
//
// Each command is a read-modify-write: the accepting edge launches the table reads, and
// in the following cycle (busy high) the entry is modified and written back. A new
// command is not accepted until the read-modify-write over the two tables is done.
// A report appears on the strobe for one cycle, in the cycle after the write-back; the
// receiver cannot stall it, and the next command is taken while it is shown.
// The synchronous reset clears the per-entry flags held in flip-flops, so no clearing pass
// runs and a command may be issued in the first cycle after reset.
module pin_change_report_engine
    import pcre_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Command transaction.
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [PIN_W-1:0]    i_pin,
    input  logic                i_report_on,
    input  logic [VALUE_W-1:0]  i_threshold,
    input  logic [ACTION_W-1:0] i_reporting_action,
    input  logic [VALUE_W-1:0]  i_sample,
    input  logic [TIME_W-1:0]   i_now_ms,
    // Configuration transaction.
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [IVL_W-1:0]    i_cfg_data,
    // Report transaction.
    output logic                o_report_valid,
    output logic                o_report_kind,
    output logic [PIN_W-1:0]    o_report_pin,
    output logic [VALUE_W-1:0]  o_report_value
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // Control state.
    logic                       r_state, n_state;
    logic [DIGITAL_PINS-1:0]    r_dig_set, n_dig_set;
    logic [DIGITAL_PINS-1:0]    r_dig_en, n_dig_en;
    logic [ANALOG_CHANNELS-1:0] r_ana_cfg, n_ana_cfg;
    logic [ANALOG_CHANNELS-1:0] r_ana_en, n_ana_en;
    logic [TIME_W-1:0]          r_last_scan, n_last_scan;
    logic                       r_window, n_window;
    logic [IVL_W-1:0]           r_interval, n_interval;
    logic                       r_report_valid, n_report_valid;

    // Captured command and report payload.
    logic [CMD_W-1:0]    r_cmd;
    logic [PIN_W-1:0]    r_pin;
    logic                r_report_on;
    logic [VALUE_W-1:0]  r_threshold;
    logic [ACTION_W-1:0] r_action;
    logic [VALUE_W-1:0]  r_sample;
    logic [TIME_W-1:0]   r_now;
    logic                r_report_kind, n_report_kind;
    logic [PIN_W-1:0]    r_report_pin, n_report_pin;
    logic [VALUE_W-1:0]  r_report_value, n_report_value;

    logic w_accept;

    // Table ports.
    logic [DIG_WORD_W-1:0] w_dig_rd, w_dig_wd;
    logic [ANA_WORD_W-1:0] w_ana_rd, w_ana_wd;
    logic                  w_dig_we, w_ana_we;

    // Decoded entry contents.
    logic [DIG_AW-1:0]  w_dix;
    logic [ANA_AW-1:0]  w_aix;
    logic               w_dig_ok, w_ana_ok;
    logic [MODE_W-1:0]  w_mode;
    logic               w_level, w_new_level;
    logic [VALUE_W-1:0] w_last, w_deadband, w_value, w_diff;
    logic [TIME_W-1:0]  w_elapsed;

    assign busy        = (r_state == ST_EXEC);
    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    // The tables are read at the accepting edge and written back in the following cycle.
    // The next read can only come at an edge after that write, so no forwarding is needed.
    pcre_ram #(
        .WIDTH (DIG_WORD_W),
        .DEPTH (DIGITAL_PINS)
    ) u_dig_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (i_pin[DIG_AW-1:0]),
        .o_rd_data (w_dig_rd),
        .i_wr_en   (w_dig_we),
        .i_wr_addr (w_dix),
        .i_wr_data (w_dig_wd)
    );

    pcre_ram #(
        .WIDTH (ANA_WORD_W),
        .DEPTH (ANALOG_CHANNELS)
    ) u_ana_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (i_pin[ANA_AW-1:0]),
        .o_rd_data (w_ana_rd),
        .i_wr_en   (w_ana_we),
        .i_wr_addr (w_aix),
        .i_wr_data (w_ana_wd)
    );

    assign w_dix    = r_pin[DIG_AW-1:0];
    assign w_aix    = r_pin[ANA_AW-1:0];
    assign w_dig_ok = (int'(r_pin) < DIGITAL_PINS);
    assign w_ana_ok = (int'(r_pin) < ANALOG_CHANNELS);

    // A digital entry that was never written reads as mode not set and level low. Every
    // digital write sets a mode, so the set flag doubles as the entry's valid bit.
    assign w_mode  = r_dig_set[w_dix] ? w_dig_rd[DIG_WORD_W-1:1] : MODE_NONE;
    assign w_level = r_dig_set[w_dix] ? w_dig_rd[0] : 1'b0;

    // Analog entries are only ever written once the channel is configured, so the
    // configured flag marks whether the stored last value is real.
    assign w_last     = r_ana_cfg[w_aix] ? w_ana_rd[ANA_WORD_W-1:VALUE_W] : '0;
    assign w_deadband = w_ana_rd[VALUE_W-1:0];

    assign w_new_level = (r_sample != '0);
    assign w_value     = r_sample & ADC_MASK;
    assign w_diff      = (w_value >= w_last) ? (w_value - w_last) : (w_last - w_value);
    assign w_elapsed   = r_now - r_last_scan;

    always_comb begin
        n_state        = ST_IDLE;
        n_dig_set      = r_dig_set;
        n_dig_en       = r_dig_en;
        n_ana_cfg      = r_ana_cfg;
        n_ana_en       = r_ana_en;
        n_last_scan    = r_last_scan;
        n_window       = r_window;
        n_interval     = r_interval;
        n_report_valid = 1'b0;
        n_report_kind  = r_report_kind;
        n_report_pin   = r_report_pin;
        n_report_value = r_report_value;
        w_dig_we       = 1'b0;
        w_dig_wd       = {w_mode, w_level};
        w_ana_we       = 1'b0;
        w_ana_wd       = {w_last, w_deadband};

        if (r_state == ST_IDLE) begin
            if (w_accept) begin
                n_state = ST_EXEC;
            end
        end else begin
            case (r_cmd)
                CMD_INPUT, CMD_PULLUP: begin
                    if (w_dig_ok) begin
                        w_dig_we        = 1'b1;
                        w_dig_wd        = {(r_cmd == CMD_INPUT) ? MODE_INPUT : MODE_PULLUP,
                                           w_level};
                        n_dig_set[w_dix] = 1'b1;
                        n_dig_en[w_dix]  = r_report_on;
                    end
                end
                CMD_OUTPUT: begin
                    // Output pins keep their enable but never report.
                    if (w_dig_ok) begin
                        w_dig_we         = 1'b1;
                        w_dig_wd         = {MODE_OUTPUT, w_level};
                        n_dig_set[w_dix] = 1'b1;
                    end
                end
                CMD_ANALOG: begin
                    if (w_ana_ok) begin
                        w_ana_we         = 1'b1;
                        w_ana_wd         = {w_last, r_threshold};
                        n_ana_cfg[w_aix] = 1'b1;
                        n_ana_en[w_aix]  = r_report_on;
                    end
                end
                CMD_REPORTING: begin
                    case (r_action)
                        ACT_DISABLE_ALL: begin
                            n_dig_en = '0;
                            n_ana_en = '0;
                        end
                        ACT_ANALOG_ON, ACT_ANALOG_OFF: begin
                            if (w_ana_ok && r_ana_cfg[w_aix]) begin
                                n_ana_en[w_aix] = (r_action == ACT_ANALOG_ON);
                            end
                        end
                        ACT_DIGITAL_ON, ACT_DIGITAL_OFF: begin
                            if (w_dig_ok && (w_mode != MODE_NONE)) begin
                                n_dig_en[w_dix] = (r_action == ACT_DIGITAL_ON);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_DIG_SAMPLE: begin
                    if (w_dig_ok && (w_mode inside {MODE_INPUT, MODE_PULLUP}) &&
                        r_dig_en[w_dix] && (w_new_level != w_level)) begin
                        w_dig_we       = 1'b1;
                        w_dig_wd       = {w_mode, w_new_level};
                        n_report_valid = 1'b1;
                        n_report_kind  = REPORT_DIGITAL;
                        n_report_pin   = r_pin;
                        n_report_value = VALUE_W'(w_new_level);
                    end
                end
                CMD_SCAN_BEGIN: begin
                    // The stored time advances by one interval, not to the current time,
                    // so a late scan catches up over the following scans.
                    if (w_elapsed > TIME_W'(r_interval)) begin
                        n_last_scan = r_last_scan + TIME_W'(r_interval);
                        n_window    = 1'b1;
                    end else begin
                        n_window    = 1'b0;
                    end
                end
                CMD_ANA_SAMPLE: begin
                    if (r_window && w_ana_ok && r_ana_cfg[w_aix] && r_ana_en[w_aix] &&
                        (w_diff >= w_deadband)) begin
                        w_ana_we       = 1'b1;
                        w_ana_wd       = {w_value, w_deadband};
                        n_report_valid = 1'b1;
                        n_report_kind  = REPORT_ANALOG;
                        n_report_pin   = r_pin;
                        n_report_value = w_value;
                    end
                end
                CMD_RESET_TIMING: begin
                    n_last_scan = '0;
                    n_interval  = DEFAULT_INTERVAL;
                    n_window    = 1'b0;
                end
                default: begin
                end
            endcase
        end

        // The user must issue configuration writes only while the engine is idle; the block does not enforce it.
        if (i_cfg_valid && o_cfg_ready) begin
            n_interval = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_dig_set      <= '0;
            r_dig_en       <= '0;
            r_ana_cfg      <= '0;
            r_ana_en       <= '0;
            r_last_scan    <= '0;
            r_window       <= 1'b0;
            r_interval     <= DEFAULT_INTERVAL;
            r_report_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_dig_set      <= n_dig_set;
            r_dig_en       <= n_dig_en;
            r_ana_cfg      <= n_ana_cfg;
            r_ana_en       <= n_ana_en;
            r_last_scan    <= n_last_scan;
            r_window       <= n_window;
            r_interval     <= n_interval;
            r_report_valid <= n_report_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd       <= i_cmd;
            r_pin       <= i_pin;
            r_report_on <= i_report_on;
            r_threshold <= i_threshold;
            r_action    <= i_reporting_action;
            r_sample    <= i_sample;
            r_now       <= i_now_ms;
        end
        r_report_kind  <= n_report_kind;
        r_report_pin   <= n_report_pin;
        r_report_value <= n_report_value;
    end

    assign o_report_valid = r_report_valid;
    assign o_report_kind  = r_report_kind;
    assign o_report_pin   = r_report_pin;
    assign o_report_value = r_report_value;

    // A report only follows a write-back cycle.
    `PCRE_ASSERT_NOW(a_report_after_exec, i_clk, i_rst_n, o_report_valid,
                     $past(r_state) == ST_EXEC)
    // An accepted command always occupies the following cycle.
    `PCRE_ASSERT_NEXT(a_accept_then_busy, i_clk, i_rst_n, w_accept, busy)
    // Analog reports are only made inside an open scan window.
    `PCRE_ASSERT_NOW(a_analog_in_window, i_clk, i_rst_n,
                     o_report_valid && (o_report_kind == REPORT_ANALOG), r_window)
    // Digital reports are only made on pins that have reporting enabled.
    `PCRE_ASSERT_NOW(a_digital_enabled, i_clk, i_rst_n,
                     o_report_valid && (o_report_kind == REPORT_DIGITAL),
                     r_dig_en[o_report_pin[DIG_AW-1:0]])

endmodule

// ===== design/pcre_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module pcre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
